/* sv/cwf_pkg.sv */
// shared types and constants for the carrot waypoint follower
// no dependencies; imported by all modules of the block
`default_nettype none
package cwf_pkg;

  localparam int WP_DEPTH   = 64;
  localparam int WP_AW      = 6;
  localparam int SQ_STEPS   = 34;
  localparam int DIV_STEPS  = 33;
  localparam logic [6:0] CNT_MIN = 7'd3;
  localparam logic [6:0] CNT_MAX = 7'd64;

  localparam logic [1:0] ST_BEFORE = 2'd0;
  localparam logic [1:0] ST_ON     = 2'd1;
  localparam logic [1:0] ST_PAST   = 2'd2;

  localparam logic REG_LOOK_AHEAD = 1'b0;
  localparam logic REG_WP_COUNT   = 1'b1;

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    logic              mode;
    logic [5:0]        wp_slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] carrot_x;
    logic signed [31:0] carrot_y;
    logic signed [31:0] carrot_z;
    logic [1:0]         segment_status;
    logic               finished;
    logic [5:0]         segment_index;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_LATCH, OP_DIFF, OP_MUL, OP_ACC, OP_CLASS,
    OP_SQ_INIT, OP_SQ_STEP, OP_MUL_LO, OP_MUL_HI, OP_MUL_LA,
    OP_DIV_INIT, OP_DIV_STEP, OP_Q_SAVE, OP_SUM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic early;
  } stat_t;

endpackage
`default_nettype wire

/* sv/cwf_ctrl.sv */
// sequencer for the carrot waypoint follower
// depends on cwf_pkg; drives the command struct of cwf_datapath
`default_nettype none
module cwf_ctrl import cwf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_mode,
  input  stat_t stat,
  output logic  in_stall,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_MUL, S_ACC, S_CLASS, S_SQI, S_SQS, S_MLO, S_MHI,
    S_DVI, S_DVS, S_QSV, S_MLA, S_SUM, S_OUT
  } state_t;

  state_t     state;
  logic [5:0] cnt;
  logic [1:0] axis;
  logic       sel;

  assign in_stall = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd.axis = axis;
    cmd.sel  = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) cmd.op = (in_mode == MODE_LOAD) ? OP_LOAD : OP_LATCH;
        else cmd.op = OP_NONE;
      end
      S_DIFF:  cmd.op = OP_DIFF;
      S_MUL:   cmd.op = OP_MUL;
      S_ACC:   cmd.op = OP_ACC;
      S_CLASS: cmd.op = OP_CLASS;
      S_SQI:   cmd.op = OP_SQ_INIT;
      S_SQS:   cmd.op = OP_SQ_STEP;
      S_MLO:   cmd.op = OP_MUL_LO;
      S_MHI:   cmd.op = OP_MUL_HI;
      S_MLA:   cmd.op = OP_MUL_LA;
      S_DVI:   cmd.op = OP_DIV_INIT;
      S_DVS:   cmd.op = OP_DIV_STEP;
      S_QSV:   cmd.op = OP_Q_SAVE;
      S_SUM:   cmd.op = OP_SUM;
      S_OUT:   cmd.op = stat.out_free ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= '0;
      sel   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_mode != MODE_LOAD) state <= S_DIFF;
        end
        S_DIFF: begin
          axis  <= '0;
          sel   <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (axis == 2'd2) begin
            axis <= '0;
            if (!sel) begin
              sel   <= 1'b1;
              state <= S_MUL;
            end else begin
              state <= S_CLASS;
            end
          end else begin
            axis  <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_CLASS: state <= stat.early ? S_OUT : S_SQI;
        S_SQI: begin
          cnt   <= '0;
          state <= S_SQS;
        end
        S_SQS: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(SQ_STEPS - 1)) begin
            axis  <= '0;
            sel   <= 1'b0;
            state <= S_MLO;
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_DVI;
        S_MLA: state <= S_DVI;
        S_DVI: begin
          cnt   <= '0;
          state <= S_DVS;
        end
        S_DVS: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) state <= S_QSV;
        end
        S_QSV: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_MLA;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          sel <= 1'b0;
          if (axis == 2'd2) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_MLO;
          end
        end
        S_OUT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/cwf_datapath.sv */
// datapath: waypoint stores, shared multiplier, square root and divider units
// depends on cwf_pkg; sequenced by cwf_ctrl
`default_nettype none
module cwf_datapath import cwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        out_stall,
  output stat_t       stat,
  output logic        out_valid,
  output out_t        out_data
);

  logic [31:0] mem_x [WP_DEPTH];
  logic [31:0] mem_y [WP_DEPTH];
  logic [31:0] mem_z [WP_DEPTH];

  logic [30:0] look_ahead;
  logic [6:0]  waypoint_count;
  logic [WP_AW-1:0] seg;

  logic signed [31:0] s_c [3];
  logic signed [31:0] e_c [3];
  logic signed [31:0] p_c [3];
  logic signed [31:0] c_c [3];
  logic [32:0] md [3];
  logic [32:0] mv [3];
  logic        sd [3];
  logic        sv [3];

  logic [65:0] prod, n2, pos, neg, dot;
  logic [65:0] num_lo, num_hi;
  logic [1:0]  status;
  logic [67:0] sq_val;
  logic [37:0] sq_rem;
  logic [34:0] sq_root;
  logic [65:0] dv_rem, dv_d;
  logic [32:0] dv_q;
  logic [32:0] off_q;
  logic [30:0] la_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      look_ahead     <= 31'd65536;
      waypoint_count <= CNT_MIN;
    end else if (cfg_we) begin
      if (cfg_index == REG_LOOK_AHEAD) look_ahead <= cfg_data;
      else waypoint_count <= cfg_data[6:0];
    end
  end

  // waypoint stores, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem_x[in_data.wp_slot] <= in_data.coord_x;
      mem_y[in_data.wp_slot] <= in_data.coord_y;
      mem_z[in_data.wp_slot] <= in_data.coord_z;
    end
    if (cmd.op == OP_LATCH) begin
      s_c[0] <= mem_x[seg - 6'd1];
      s_c[1] <= mem_y[seg - 6'd1];
      s_c[2] <= mem_z[seg - 6'd1];
      e_c[0] <= mem_x[seg];
      e_c[1] <= mem_y[seg];
      e_c[2] <= mem_z[seg];
    end
  end

  // differences per axis
  logic signed [32:0] d_w [3];
  logic signed [32:0] v_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {e_c[i][31], e_c[i]} - {s_c[i][31], s_c[i]};
      v_w[i] = {p_c[i][31], p_c[i]} - {s_c[i][31], s_c[i]};
    end
  end

  // shared multiplier operand select
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  always_comb begin
    case (cmd.op)
      OP_MUL: begin
        mul_a = cmd.sel ? mv[cmd.axis] : md[cmd.axis];
        mul_b = md[cmd.axis];
      end
      OP_MUL_LO: begin
        mul_a = md[cmd.axis];
        mul_b = dot[32:0];
      end
      OP_MUL_HI: begin
        mul_a = md[cmd.axis];
        mul_b = {dot[65:33]};
      end
      OP_MUL_LA: begin
        mul_a = {2'b00, look_ahead};
        mul_b = md[cmd.axis];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // classification of the projection
  logic        zero_len, is_before, is_past;
  logic [65:0] dot_w;
  assign dot_w     = pos - neg;
  assign zero_len  = (n2 == '0);
  assign is_before = !zero_len && (neg > pos);
  assign is_past   = !zero_len && !is_before && (dot_w > n2);

  // square root step
  logic [37:0] sq_r4, sq_trial;
  assign sq_r4    = {sq_rem[35:0], sq_val[67:66]};
  assign sq_trial = {1'b0, sq_root, 2'b01};

  // divider init and step
  logic [98:0] num_w;
  logic [66:0] dv_t;
  logic        dv_ge;
  assign num_w = {num_hi[65:0], 33'd0} + {33'd0, num_lo};
  assign dv_t  = {dv_rem, dv_q[32]};
  assign dv_ge = (dv_t >= {1'b0, dv_d});

  // carrot sum with saturation
  logic [33:0]        sum_mag;
  logic signed [35:0] sum_off, sum_w;
  logic signed [31:0] sum_sat;
  always_comb begin
    sum_mag = {1'b0, off_q} + {3'b000, la_q};
    sum_off = sd[cmd.axis] ? -$signed({2'b00, sum_mag}) : $signed({2'b00, sum_mag});
    sum_w   = {{4{s_c[cmd.axis][31]}}, s_c[cmd.axis]} + sum_off;
    if (sum_w > 36'sd2147483647) sum_sat = 32'sh7fffffff;
    else if (sum_w < -36'sd2147483648) sum_sat = 32'sh80000000;
    else sum_sat = sum_w[31:0];
  end

  // finished test with clamped count
  logic [6:0] cnt_c;
  logic       fin;
  always_comb begin
    if (waypoint_count < CNT_MIN) cnt_c = CNT_MIN;
    else if (waypoint_count > CNT_MAX) cnt_c = CNT_MAX;
    else cnt_c = waypoint_count;
  end
  assign fin = ({1'b0, seg} + 7'd1) >= cnt_c;

  assign stat.out_free = !out_valid || !out_stall;
  assign stat.early    = zero_len || is_before || is_past;

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        p_c[0] <= in_data.coord_x;
        p_c[1] <= in_data.coord_y;
        p_c[2] <= in_data.coord_z;
      end
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          md[i] <= d_w[i][32] ? 33'(-d_w[i]) : 33'(d_w[i]);
          mv[i] <= v_w[i][32] ? 33'(-v_w[i]) : 33'(v_w[i]);
          sd[i] <= d_w[i][32];
          sv[i] <= v_w[i][32];
        end
        n2  <= '0;
        pos <= '0;
        neg <= '0;
      end
      OP_MUL: prod <= mul_p;
      OP_ACC: begin
        if (!cmd.sel) n2 <= n2 + prod;
        else if (sv[cmd.axis] != sd[cmd.axis]) neg <= neg + prod;
        else pos <= pos + prod;
      end
      OP_CLASS: begin
        dot <= dot_w;
        for (int i = 0; i < 3; i++) c_c[i] <= is_past ? e_c[i] : s_c[i];
        if (is_before) status <= ST_BEFORE;
        else if (is_past) status <= ST_PAST;
        else status <= ST_ON;
      end
      OP_SQ_INIT: begin
        sq_val  <= {2'b00, n2};
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_SQ_STEP: begin
        sq_val <= {sq_val[65:0], 2'b00};
        if (sq_r4 >= sq_trial) begin
          sq_rem  <= sq_r4 - sq_trial;
          sq_root <= {sq_root[33:0], 1'b1};
        end else begin
          sq_rem  <= sq_r4;
          sq_root <= {sq_root[33:0], 1'b0};
        end
      end
      OP_MUL_LO: num_lo <= mul_p;
      OP_MUL_HI: num_hi <= mul_p;
      OP_MUL_LA: begin
        num_lo <= mul_p;
        num_hi <= '0;
      end
      OP_DIV_INIT: begin
        dv_rem <= num_w[98:33];
        dv_q   <= num_w[32:0];
        dv_d   <= cmd.sel ? {32'd0, sq_root[33:0]} : n2;
      end
      OP_DIV_STEP: begin
        dv_rem <= dv_ge ? 66'(dv_t - {1'b0, dv_d}) : dv_t[65:0];
        dv_q   <= {dv_q[31:0], dv_ge};
      end
      OP_Q_SAVE: begin
        if (cmd.sel) la_q <= dv_q[30:0];
        else off_q <= dv_q;
      end
      OP_SUM: c_c[cmd.axis] <= sum_sat;
      default: ;
    endcase
  end

  // output register and segment tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seg       <= 6'd1;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.op == OP_LOAD) seg <= 6'd1;
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
        if (!fin && status == ST_PAST) seg <= seg + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data.carrot_x       <= c_c[0];
      out_data.carrot_y       <= c_c[1];
      out_data.carrot_z       <= c_c[2];
      out_data.segment_status <= status;
      out_data.finished       <= fin;
      out_data.segment_index  <= seg;
    end
  end

endmodule
`default_nettype wire

/* sv/carrot_waypoint_follower_core.sv */
// Carrot waypoint follower, top level.
// Input channel (in_valid/in_stall/in_data): a transfer with mode 0 writes a
// waypoint into wp_slot and restarts tracking at segment 1, giving no result.
// A transfer with mode 1 is a position; the block projects it onto the
// current segment and returns one carrot transfer on the output channel
// (out_valid/out_stall/out_data).
// A position passes through one store read, six multiply-accumulate passes,
// a 34-step square root and, per axis, two 33-step divisions on the single
// shared restoring divider; no new input is taken until its result is in the
// output register. Early exits (before start, past end, zero length) skip the
// square root and the divisions. The result sits in an output register; while
// it is stalled the block still takes load transfers, and a finished position
// waits there for the slot.
// Configuration (cfg_we/cfg_index/cfg_data) writes look_ahead (index 0) or
// waypoint_count (index 1); the user must do it only while the block is idle
// (not enforced). Synchronous reset sets look_ahead to 1.0, waypoint_count to 3
// and tracking to segment 1; waypoint contents are undefined until loaded.
// Depends on cwf_pkg, cwf_ctrl and cwf_datapath.
`default_nettype none
module carrot_waypoint_follower_core import cwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  cwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // arithmetic and storage
  cwf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
